[src/i2c_master_byte_engine_defines.svh]
// Assertion macros shared by the I2C master byte engine RTL.
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// Same-cycle implication, reset-qualified.
`define I2CM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cm assertion failed");

// Next-cycle implication, reset-qualified.
`define I2CM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cm assertion failed");

`endif

[src/i2cm_pkg.sv]
// Types, constants and helper functions for the I2C master byte engine.
package i2cm_pkg;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        SEG_START,
        SEG_STOP,
        SEG_WBIT,
        SEG_RBIT,
        SEG_WAIT
    } t_seg;

    localparam logic [15:0] PHASE_TICKS_RST = 16'd1000;
    localparam logic [7:0]  MSB_MASK        = 8'd128;
    localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;
    localparam logic [3:0]  LAST_BIT_WRITE  = 4'd8;
    localparam logic [3:0]  LAST_BIT_READ   = 4'd9;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_q_entry;

    typedef struct packed {
        logic       scl_drive_low;
        logic       sda_drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_bit;
        logic       command_ignored;
    } t_out_item;

    // Which bus segment the active command is in, by bit position.
    function automatic t_seg seg_kind(input t_cmd c, input logic [3:0] bits);
        t_seg k;
        case (c)
            CMD_START: k = SEG_START;
            CMD_STOP:  k = SEG_STOP;
            CMD_WRITE: k = (bits < BITS_PER_BYTE) ? SEG_WBIT : SEG_RBIT;
            default: begin
                if (bits < BITS_PER_BYTE)       k = SEG_RBIT;
                else if (bits == BITS_PER_BYTE) k = SEG_WBIT;
                else                            k = SEG_WAIT;
            end
        endcase
        return k;
    endfunction

    function automatic logic [1:0] seg_phases(input t_seg k);
        logic [1:0] n;
        case (k)
            SEG_START, SEG_WBIT: n = 2'd3;
            SEG_WAIT:            n = 2'd1;
            default:             n = 2'd2;
        endcase
        return n;
    endfunction

    function automatic logic [3:0] last_bit(input t_cmd c);
        logic [3:0] b;
        case (c)
            CMD_WRITE: b = LAST_BIT_WRITE;
            CMD_READ:  b = LAST_BIT_READ;
            default:   b = 4'd0;
        endcase
        return b;
    endfunction

endpackage

[src/i2cm_chan_if.sv]
// Channel interfaces: input tick beats, result beats, configuration writes.
interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;

    modport source (output valid, command, tx_byte, send_ack, sda_in, input ready);
    modport sink   (input valid, command, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_bit;
    logic       command_ignored;

    modport source (output valid, scl_drive_low, sda_drive_low, busy_res, done_res,
                    rx_byte, ack_bit, command_ignored, input ready);
    modport sink   (input valid, scl_drive_low, sda_drive_low, busy_res, done_res,
                    rx_byte, ack_bit, command_ignored, output ready);
endinterface

interface i2cm_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] phase_ticks;

    modport source (output valid, phase_ticks, input ready);
    modport sink   (input valid, phase_ticks, output ready);
endinterface

[src/i2cm_front.sv]
// Front end: takes tick beats and decodes the command code for the queue.
module i2cm_front
    import i2cm_pkg::*;
(
    i2cm_in_if.sink  i_in,
    input  logic     i_q_ready,
    output logic     o_push,
    output t_q_entry o_entry
);

    t_cmd cmd;

    // Codes 5..7 behave like no command.
    always_comb begin
        case (i_in.command)
            CMD_START, CMD_STOP, CMD_WRITE, CMD_READ: cmd = t_cmd'(i_in.command);
            default:                                  cmd = CMD_NONE;
        endcase
    end

    assign i_in.ready       = i_q_ready;
    assign o_push           = i_in.valid & i_q_ready;
    assign o_entry.cmd      = cmd;
    assign o_entry.tx_byte  = i_in.tx_byte;
    assign o_entry.send_ack = i_in.send_ack;
    assign o_entry.sda_in   = i_in.sda_in;

endmodule

[src/i2cm_queue.sv]
// Small register FIFO between the front end and the bus sequencer.
module i2cm_queue
    import i2cm_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_entry,
    output logic     o_ready,
    input  logic     i_pop,
    output logic     o_valid,
    output t_q_entry o_entry
);
`include "i2c_master_byte_engine_defines.svh"

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_q_entry         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_ready = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    `I2CM_ASSERT_IMPL(a_q_no_overflow, i_clk, i_rst_n, i_push, r_count != CNT_FULL || i_pop)
    `I2CM_ASSERT_IMPL(a_q_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0)
    `I2CM_ASSERT_IMPL(a_q_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_FULL)

endmodule

[src/i2cm_back.sv]
// Bus sequencer: runs one tick of the phase machine per beat, registers the result.
module i2cm_back
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_phase_ticks,
    input  logic        i_q_valid,
    input  t_q_entry    i_q_entry,
    output logic        o_q_pop,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output t_out_item   o_out_item
);
`include "i2c_master_byte_engine_defines.svh"

    t_cmd        r_cmd, n_cmd;
    logic [15:0] r_tick, n_tick;
    logic [1:0]  r_phase, n_phase;
    logic [3:0]  r_bits, n_bits;
    logic [7:0]  r_shift, n_shift;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic [7:0]  r_rx, n_rx;
    logic        r_ack, n_ack;
    logic        r_ack_pend, n_ack_pend;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        pop;
    logic        done;
    logic        ignored;
    logic        wdata;
    t_seg        kind;
    logic [15:0] pt;
    logic [15:0] tick_inc;

    assign pop         = i_q_valid & (~r_out_valid | i_out_ready);
    assign o_q_pop     = pop;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign pt          = (i_phase_ticks == 16'd0) ? 16'd1 : i_phase_ticks;

    always_comb begin
        n_cmd      = r_cmd;
        n_tick     = r_tick;
        n_phase    = r_phase;
        n_bits     = r_bits;
        n_shift    = r_shift;
        n_scl      = r_scl;
        n_sda      = r_sda;
        n_rx       = r_rx;
        n_ack      = r_ack;
        n_ack_pend = r_ack_pend;
        done       = 1'b0;
        ignored    = 1'b0;
        kind       = SEG_WAIT;
        wdata      = 1'b0;
        tick_inc   = 16'd0;
        if (pop) begin
            // busy engines drop new commands, idle ones latch them
            if (r_cmd != CMD_NONE) begin
                ignored = (i_q_entry.cmd != CMD_NONE);
            end else if (i_q_entry.cmd != CMD_NONE) begin
                n_cmd   = i_q_entry.cmd;
                n_bits  = 4'd0;
                n_phase = 2'd0;
                n_tick  = 16'd0;
                n_shift = (i_q_entry.cmd == CMD_WRITE) ? i_q_entry.tx_byte : 8'd0;
                if (i_q_entry.cmd == CMD_READ) begin
                    n_ack_pend = i_q_entry.send_ack;
                end
            end

            if (n_cmd != CMD_NONE) begin
                kind  = seg_kind(n_cmd, n_bits);
                wdata = (n_cmd == CMD_WRITE) ? ((n_shift & MSB_MASK) != 8'd0) : ~n_ack_pend;
                // line changes land on the first tick of each phase
                if (n_tick == 16'd0) begin
                    case (kind)
                        SEG_START: begin
                            if (n_phase == 2'd0) begin
                                n_scl = 1'b0;
                                n_sda = 1'b0;
                            end else if (n_phase == 2'd1) begin
                                n_sda = 1'b1;
                            end else begin
                                n_scl = 1'b1;
                            end
                        end
                        SEG_STOP: begin
                            if (n_phase == 2'd0) n_scl = 1'b0;
                            else                 n_sda = 1'b0;
                        end
                        SEG_WBIT: begin
                            if (n_phase == 2'd0) begin
                                n_sda = ~wdata;
                                n_scl = 1'b0;
                            end else if (n_phase == 2'd1) begin
                                n_scl = 1'b1;
                            end else if (wdata) begin
                                n_sda = 1'b1;
                            end
                        end
                        SEG_RBIT: begin
                            if (n_phase == 2'd0) begin
                                n_sda = 1'b0;
                                n_scl = 1'b0;
                            end else begin
                                n_scl = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                tick_inc = n_tick + 16'd1;
                if (tick_inc >= pt) begin
                    n_tick = 16'd0;
                    // sample SDA at the end of the clock-high phase
                    if (kind == SEG_RBIT && n_phase == 2'd0) begin
                        if (n_cmd == CMD_WRITE) n_ack = i_q_entry.sda_in;
                        else                    n_shift = {n_shift[6:0], i_q_entry.sda_in};
                    end
                    if ({1'b0, n_phase} + 3'd1 >= {1'b0, seg_phases(kind)}) begin
                        n_phase = 2'd0;
                        if (kind == SEG_WBIT && n_cmd == CMD_WRITE) begin
                            n_shift = {n_shift[6:0], 1'b0};
                        end
                        n_bits = n_bits + 4'd1;
                        if (n_bits > last_bit(n_cmd)) begin
                            if (n_cmd == CMD_READ) n_rx = n_shift;
                            n_cmd  = CMD_NONE;
                            n_bits = 4'd0;
                            done   = 1'b1;
                        end
                    end else begin
                        n_phase = n_phase + 2'd1;
                    end
                end else begin
                    n_tick = tick_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= CMD_NONE;
            r_tick      <= '0;
            r_phase     <= '0;
            r_bits      <= '0;
            r_shift     <= '0;
            r_scl       <= 1'b0;
            r_sda       <= 1'b0;
            r_rx        <= '0;
            r_ack       <= 1'b0;
            r_ack_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmd      <= n_cmd;
            r_tick     <= n_tick;
            r_phase    <= n_phase;
            r_bits     <= n_bits;
            r_shift    <= n_shift;
            r_scl      <= n_scl;
            r_sda      <= n_sda;
            r_rx       <= n_rx;
            r_ack      <= n_ack;
            r_ack_pend <= n_ack_pend;
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out.scl_drive_low   <= n_scl;
            r_out.sda_drive_low   <= n_sda;
            r_out.busy_res        <= (n_cmd != CMD_NONE);
            r_out.done_res        <= done;
            r_out.rx_byte         <= n_rx;
            r_out.ack_bit         <= n_ack;
            r_out.command_ignored <= ignored;
        end
    end

    `I2CM_ASSERT_IMPL(a_busy_tracks_cmd, i_clk, i_rst_n, r_out_valid, r_out.busy_res == (r_cmd != CMD_NONE))
    `I2CM_ASSERT_IMPL(a_bits_in_range, i_clk, i_rst_n, 1'b1, r_bits <= LAST_BIT_READ)
    `I2CM_ASSERT_NEXT(a_free_slot_fills, i_clk, i_rst_n, i_q_valid && !r_out_valid, r_out_valid)

endmodule

[src/i2c_master_byte_engine.sv]
// Top level of the I2C master byte engine: front end, beat queue, bus sequencer.
// A tick beat is written into the queue memory, and its result beat is then held in the sequencer's output register.
// Throughput: one tick beat per cycle sustained while the output accepts results; the sequencer steps once per beat.
// Input ready drops only when the queue is full, i.e. when results back up on the output.
// Reset (sync, active low): both bus lines released, engine idle, queue empty,
// phase_ticks back to 1000; no clearing pass, beats are taken right after reset.
module i2c_master_byte_engine
    import i2cm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    i2cm_in_if.sink    i_in,
    i2cm_out_if.source o_out,
    i2cm_cfg_if.sink   i_cfg
);

    // Bus phase length; software writes it only while the engine is idle (not enforced by the block).
    logic [15:0] r_phase_ticks;

    logic      q_ready;
    logic      q_push;
    t_q_entry  q_in_entry;
    logic      q_valid;
    logic      q_pop;
    t_q_entry  q_out_entry;
    logic      out_valid;
    t_out_item out_item;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
        end else if (i_cfg.valid) begin
            r_phase_ticks <= i_cfg.phase_ticks;
        end
    end

    // Front end: decode the command code of each tick beat.
    i2cm_front u_front (
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (q_push),
        .o_entry   (q_in_entry)
    );

    // Decouples input acceptance from output back-pressure.
    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in_entry),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_out_entry)
    );

    // Back end: phase/bit sequencer plus output register.
    i2cm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_phase_ticks (r_phase_ticks),
        .i_q_valid     (q_valid),
        .i_q_entry     (q_out_entry),
        .o_q_pop       (q_pop),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (out_valid),
        .o_out_item    (out_item)
    );

    assign o_out.valid           = out_valid;
    assign o_out.scl_drive_low   = out_item.scl_drive_low;
    assign o_out.sda_drive_low   = out_item.sda_drive_low;
    assign o_out.busy_res        = out_item.busy_res;
    assign o_out.done_res        = out_item.done_res;
    assign o_out.rx_byte         = out_item.rx_byte;
    assign o_out.ack_bit         = out_item.ack_bit;
    assign o_out.command_ignored = out_item.command_ignored;

endmodule
